FILE: rtl/core/tfwc_pkg.sv
`timescale 1ns / 1ps
package tfwc_pkg;

    localparam int FRAME_NUMBER_MODULUS = 8;
    localparam int FN_W = $clog2(FRAME_NUMBER_MODULUS);
    localparam int BYTE_W = 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QA_W = $clog2(QUEUE_DEPTH);

    localparam logic [BYTE_W-1:0] CH_STX  = 8'h02;
    localparam logic [BYTE_W-1:0] CH_ETX  = 8'h03;
    localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              open;
        logic [BYTE_W-1:0] digit;
        logic [BYTE_W-1:0] checksum;
    } t_job;

endpackage

FILE: rtl/core/tfwc_in_if.sv
`timescale 1ns / 1ps
interface tfwc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       frame_last;

    modport source (output valid, output payload_byte, output frame_last, input ready);
    modport sink (input valid, input payload_byte, input frame_last, output ready);
endinterface

FILE: rtl/core/tfwc_out_if.sv
`timescale 1ns / 1ps
interface tfwc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;

    modport source (output valid, output out_byte, output run_last, output frame_end,
                    input ready);
    modport sink (input valid, input out_byte, input run_last, input frame_end,
                  output ready);
endinterface

FILE: rtl/core/tfwc_front.sv
`timescale 1ns / 1ps
module tfwc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tfwc_in_if.sink       i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output tfwc_pkg::t_job o_job
);
    import tfwc_pkg::*;

    logic [FN_W-1:0]   r_frame_num, n_frame_num;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic              r_open, n_open;
    logic [BYTE_W-1:0] digit;
    logic [BYTE_W-1:0] sum_base;
    logic [BYTE_W-1:0] sum_new;
    logic              accept;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign o_push     = accept;

    always_comb begin
        digit    = CH_ZERO + BYTE_W'(r_frame_num);
        sum_base = r_open ? r_sum : digit;
        sum_new  = sum_base + i_in.payload_byte;

        o_job.data     = i_in.payload_byte;
        o_job.last     = i_in.frame_last;
        o_job.open     = !r_open;
        o_job.digit    = digit;
        o_job.checksum = sum_new + CH_ETX;

        n_frame_num = r_frame_num;
        n_sum       = r_sum;
        n_open      = r_open;
        if (accept) begin
            if (i_in.frame_last) begin
                n_open = 1'b0;
                n_sum  = '0;
                if (r_frame_num == FN_W'(FRAME_NUMBER_MODULUS - 1)) begin
                    n_frame_num = '0;
                end else begin
                    n_frame_num = r_frame_num + 1'b1;
                end
            end else begin
                n_open = 1'b1;
                n_sum  = sum_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_num <= FN_W'(1);
            r_sum       <= '0;
            r_open      <= 1'b0;
        end else begin
            r_frame_num <= n_frame_num;
            r_sum       <= n_sum;
            r_open      <= n_open;
        end
    end

`ifndef ASSERT_OFF
    a_num_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_frame_num} < (FN_W+1)'(FRAME_NUMBER_MODULUS))
        else $error("frame number out of range");
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.frame_last |=> !r_open && r_sum == '0)
        else $error("frame not closed after last byte");
    a_open_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_open |-> r_sum == '0)
        else $error("stale checksum with no open frame");
`endif
endmodule

FILE: rtl/core/tfwc_queue.sv
`timescale 1ns / 1ps
module tfwc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tfwc_pkg::t_job i_push_job,
    output logic           o_full,
    input  logic           i_pop,
    output tfwc_pkg::t_job o_head,
    output logic           o_head_valid
);
    import tfwc_pkg::*;

    t_job            r_mem [QUEUE_DEPTH];
    logic [QA_W-1:0] r_wr_ptr;
    logic [QA_W-1:0] r_rd_ptr;
    logic [QA_W:0]   r_count;

    assign o_full       = (r_count == (QA_W+1)'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("pop from empty queue");
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || o_full) |-> r_wr_ptr == r_rd_ptr)
        else $error("pointers disagree with count");
`endif
endmodule

FILE: rtl/core/tfwc_back.sv
`timescale 1ns / 1ps
module tfwc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tfwc_pkg::t_job i_head,
    input  logic           i_head_valid,
    output logic           o_pop,
    tfwc_out_if.source     o_out
);
    import tfwc_pkg::*;

    localparam logic [2:0] PH_STX   = 3'd0;
    localparam logic [2:0] PH_DIGIT = 3'd1;
    localparam logic [2:0] PH_DATA  = 3'd2;
    localparam logic [2:0] PH_ETX   = 3'd3;
    localparam logic [2:0] PH_HI    = 3'd4;
    localparam logic [2:0] PH_LO    = 3'd5;
    localparam logic [2:0] PH_CR    = 3'd6;
    localparam logic [2:0] PH_LF    = 3'd7;

    function automatic logic [BYTE_W-1:0] hex_ascii(input logic [3:0] nib);
        if (nib < 4'd10) begin
            hex_ascii = CH_ZERO + {4'h0, nib};
        end else begin
            hex_ascii = 8'h37 + {4'h0, nib};
        end
    endfunction

    logic [2:0]        r_phase;
    logic              r_mid;
    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_run_last;
    logic              r_frame_end;

    logic [2:0]        cur_phase;
    logic [2:0]        nxt_phase;
    logic              done;
    logic              load;
    logic [BYTE_W-1:0] n_byte;
    logic              n_run_last;
    logic              n_frame_end;

    assign cur_phase = r_mid ? r_phase : (i_head.open ? PH_STX : PH_DATA);
    assign load      = i_head_valid && (!r_valid || o_out.ready);
    assign o_pop     = load && done;

    always_comb begin
        n_byte      = '0;
        n_run_last  = 1'b0;
        n_frame_end = 1'b0;
        nxt_phase   = cur_phase;
        done        = 1'b0;
        unique case (cur_phase)
            PH_STX: begin
                n_byte    = CH_STX;
                nxt_phase = PH_DIGIT;
            end
            PH_DIGIT: begin
                n_byte    = i_head.digit;
                nxt_phase = PH_DATA;
            end
            PH_DATA: begin
                n_byte     = i_head.data;
                n_run_last = !i_head.last;
                done       = !i_head.last;
                nxt_phase  = PH_ETX;
            end
            PH_ETX: begin
                n_byte    = CH_ETX;
                nxt_phase = PH_HI;
            end
            PH_HI: begin
                n_byte    = hex_ascii(i_head.checksum[7:4]);
                nxt_phase = PH_LO;
            end
            PH_LO: begin
                n_byte    = hex_ascii(i_head.checksum[3:0]);
                nxt_phase = PH_CR;
            end
            PH_CR: begin
                n_byte    = CH_CR;
                nxt_phase = PH_LF;
            end
            PH_LF: begin
                n_byte      = CH_LF;
                n_run_last  = 1'b1;
                n_frame_end = 1'b1;
                done        = 1'b1;
            end
            default: begin
                n_byte = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid   <= 1'b0;
            r_phase <= PH_STX;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_mid   <= !done;
                r_phase <= nxt_phase;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte      <= n_byte;
            r_run_last  <= n_run_last;
            r_frame_end <= n_frame_end;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.out_byte  = r_byte;
    assign o_out.run_last  = r_run_last;
    assign o_out.frame_end = r_frame_end;

`ifndef ASSERT_OFF
    a_mid_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid |-> i_head_valid)
        else $error("request in progress without queue entry");
    a_end_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_frame_end |-> r_run_last && r_byte == CH_LF)
        else $error("frame end not on closing LF");
    a_lf_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && cur_phase == PH_LF |=> !r_mid)
        else $error("request not finished after LF");
`endif
endmodule

FILE: rtl/core/text_frame_wrapper_checksum_top.sv
`timescale 1ns / 1ps
// A request is stored in the queue, then the sequencer registers its first byte for output.
// Throughput: one output byte per cycle while the output is ready and a request is queued;
// requests emit 1 byte mid-frame, 3 opening a frame, 6 closing one, 8 for a one-byte frame.
// A 4-entry queue between classifier and sequencer absorbs frame open and close bursts.
// Reset (synchronous, active low): frame number 1, checksum 0, no frame open, queue empty.
module text_frame_wrapper_checksum_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tfwc_in_if.sink    i_in,
    tfwc_out_if.source o_out
);
    import tfwc_pkg::*;

    logic q_full;
    logic push;
    t_job push_job;
    logic pop;
    t_job head;
    logic head_valid;

    tfwc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    tfwc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_job   (push_job),
        .o_full       (q_full),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid)
    );

    tfwc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_out        (o_out)
    );
endmodule
